// ===== rtl/irrigation_pulse_soak_scheduler_defines.svh =====
// assertion macros shared by the scheduler rtl
`ifndef IRRIGATION_PULSE_SOAK_SCHEDULER_DEFINES_SVH
`define IRRIGATION_PULSE_SOAK_SCHEDULER_DEFINES_SVH

// condition holds at every clock outside reset
`define IPSS_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define IPSS_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== rtl/ipss_pkg.sv =====
// ----------------------------------------------------------------------------
// ipss_pkg
// types, constants and codes shared by the pulse/soak scheduler
// ----------------------------------------------------------------------------
package ipss_pkg;

	localparam int MAX_ZONES = 16;
	localparam int IDX_W     = $clog2(MAX_ZONES);
	localparam int CNT_W     = IDX_W + 1;

	localparam logic [23:0] RUNTIME_MAX  = 24'hFFFFFF;
	localparam logic [31:0] TIME_MAX     = 32'hFFFFFFFF;
	localparam logic [7:0]  VIP_RESET    = 8'd1;

	typedef enum logic [1:0] {
		CMD_ACTIVATE = 2'd0,
		CMD_STOP     = 2'd1,
		CMD_TICK     = 2'd2,
		CMD_NOP      = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_ACT_SCAN, S_PRUNE_IDX, S_PRUNE_CHK, S_TICK_GO,
		S_MOD_WAIT, S_SCAN, S_EL_WAIT, S_EL_MUL, S_EL_CMP, S_SEL_BEST,
		S_START, S_IDLE_CHK, S_IDLE_SCAN, S_OUT
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_CAPTURE, OP_IGNORE, OP_ACT_UPDATE, OP_APPEND, OP_STOP,
		OP_IDX_INC, OP_PRUNE_IDX, OP_PRUNE_POP, OP_TICK_BEGIN, OP_MOD_DONE,
		OP_EL_DIV, OP_EL_MUL, OP_EL_CMP, OP_SEL_BEST, OP_START,
		OP_IDLE_SET, OP_IDLE_CLR, OP_IDLE_BEGIN, OP_OUT_LOAD
	} op_t;

	typedef struct packed {
		cmd_t cmd;
		logic rej;
		logic at_end;
		logic zone_match;
		logic full;
		logic cnt_zero;
		logic prune_ok;
		logic now_zero;
		logic now_gt_busy;
		logic div_done;
		logic cand;
		logic p_zero;
		logic pick_valid;
		logic pulse_end_ge;
		logic rt_nz;
		logic out_free;
	} ipss_status_t;

endpackage

// ===== rtl/ipss_div.sv =====
// ----------------------------------------------------------------------------
// ipss_div
// restoring divider, 32-bit dividend by 16-bit divisor, one bit per cycle
// ----------------------------------------------------------------------------
module ipss_div import ipss_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [15:0] divisor,
	output logic        done,
	output logic [31:0] quot,
	output logic [15:0] rem
);

	logic [31:0] quo_q;
	logic [15:0] rem_q;
	logic [15:0] dvs_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [16:0] trial;
	logic        take;

	assign trial = {rem_q, quo_q[31]};
	assign take  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[30:0], take};
			rem_q <= take ? 16'(trial - {1'b0, dvs_q}) : trial[15:0];
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;

endmodule

// ===== rtl/ipss_ctrl.sv =====
// ----------------------------------------------------------------------------
// ipss_ctrl
// sequencer issuing at most one datapath operation per cycle
// ----------------------------------------------------------------------------
module ipss_ctrl import ipss_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  ipss_status_t st,
	output op_t          op
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		op       = OP_NONE;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					op      = OP_CAPTURE;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (st.cmd)
					CMD_ACTIVATE: begin
						if (st.rej) begin
							op      = OP_IGNORE;
							state_d = S_IDLE_CHK;
						end else begin
							state_d = S_ACT_SCAN;
						end
					end
					CMD_STOP: begin
						op      = OP_STOP;
						state_d = S_IDLE_CHK;
					end
					CMD_TICK: state_d = st.now_zero ? S_IDLE_CHK : S_PRUNE_IDX;
					default:  state_d = S_IDLE_CHK;
				endcase
			end
			S_ACT_SCAN: begin
				priority if (st.at_end) begin
					op      = st.full ? OP_IGNORE : OP_APPEND;
					state_d = S_IDLE_CHK;
				end else if (st.zone_match) begin
					op      = OP_ACT_UPDATE;
					state_d = S_IDLE_CHK;
				end else begin
					op = OP_IDX_INC;
				end
			end
			S_PRUNE_IDX: begin
				if (st.cnt_zero) begin
					state_d = S_TICK_GO;
				end else begin
					op      = OP_PRUNE_IDX;
					state_d = S_PRUNE_CHK;
				end
			end
			S_PRUNE_CHK: begin
				if (st.prune_ok) begin
					op      = OP_PRUNE_POP;
					state_d = S_PRUNE_IDX;
				end else begin
					state_d = S_TICK_GO;
				end
			end
			S_TICK_GO: begin
				if (st.now_gt_busy) begin
					op      = OP_TICK_BEGIN;
					state_d = S_MOD_WAIT;
				end else begin
					state_d = S_IDLE_CHK;
				end
			end
			S_MOD_WAIT: begin
				op      = OP_MOD_DONE;
				state_d = S_SCAN;
			end
			S_SCAN: begin
				priority if (st.at_end) begin
					state_d = st.pick_valid ? S_SEL_BEST : S_IDLE_CHK;
				end else if (!st.cand) begin
					op = OP_IDX_INC;
				end else if (st.p_zero) begin
					state_d = S_EL_MUL;
				end else begin
					op      = OP_EL_DIV;
					state_d = S_EL_WAIT;
				end
			end
			S_EL_WAIT: begin
				if (st.div_done) state_d = S_EL_MUL;
			end
			S_EL_MUL: begin
				op      = OP_EL_MUL;
				state_d = S_EL_CMP;
			end
			S_EL_CMP: begin
				op      = OP_EL_CMP;
				state_d = S_SCAN;
			end
			S_SEL_BEST: begin
				op      = OP_SEL_BEST;
				state_d = S_START;
			end
			S_START: begin
				op      = OP_START;
				state_d = S_IDLE_CHK;
			end
			S_IDLE_CHK: begin
				priority if (st.cnt_zero) begin
					op      = OP_IDLE_SET;
					state_d = S_OUT;
				end else if (st.pulse_end_ge) begin
					op      = OP_IDLE_CLR;
					state_d = S_OUT;
				end else begin
					op      = OP_IDLE_BEGIN;
					state_d = S_IDLE_SCAN;
				end
			end
			S_IDLE_SCAN: begin
				priority if (st.at_end) begin
					state_d = S_OUT;
				end else if (st.rt_nz) begin
					op      = OP_IDLE_CLR;
					state_d = S_OUT;
				end else begin
					op = OP_IDX_INC;
				end
			end
			S_OUT: begin
				if (st.out_free) begin
					op      = OP_OUT_LOAD;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ===== rtl/ipss_dp.sv =====
// ----------------------------------------------------------------------------
// ipss_dp
// entry store, timers, selection registers and result register
// ----------------------------------------------------------------------------
`include "irrigation_pulse_soak_scheduler_defines.svh"
module ipss_dp import ipss_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  op_t          op,
	output ipss_status_t st,
	input  logic         cfg_valid,
	input  logic [7:0]   cfg_data,
	input  logic [1:0]   cmd,
	input  logic [3:0]   zone,
	input  logic [15:0]  run_seconds,
	input  logic         scheduled,
	input  logic [15:0]  hydrate_seconds,
	input  logic [15:0]  cycle_pulse,
	input  logic [15:0]  soak_pause,
	input  logic         manual_only,
	input  logic [31:0]  now_seconds,
	output logic         out_valid,
	input  logic         out_ready,
	output logic         ignored,
	output logic         start_valid,
	output logic [3:0]   start_zone,
	output logic [23:0]  start_seconds,
	output logic         start_scheduled,
	output logic         cancel_valid,
	output logic [3:0]   cancel_zone,
	output logic         active_valid,
	output logic [3:0]   active_zone,
	output logic         idle
);

	// entry store
	logic [3:0]  e_zone_q  [MAX_ZONES];
	logic [15:0] e_hyd_q   [MAX_ZONES];
	logic [23:0] e_rt_q    [MAX_ZONES];
	logic [31:0] e_next_q  [MAX_ZONES];
	logic        e_prog_q  [MAX_ZONES];
	logic [15:0] e_pulse_q [MAX_ZONES];
	logic [15:0] e_pause_q [MAX_ZONES];

	// captured transaction
	cmd_t        cmd_q;
	logic [3:0]  zone_q;
	logic [15:0] run_q, hyd_q, cpulse_q, spause_q;
	logic        sched_q, manual_q;
	logic [31:0] now_q;

	// control state
	logic [CNT_W-1:0] count_q, idx_q;
	logic [IDX_W-1:0] best_idx_q;
	logic [31:0] busy_q, pend_q;
	logic        run_v_q;
	logic [3:0]  run_z_q;
	logic [7:0]  vip_q;
	logic        mod_ok_q, pick_q;
	logic [32:0] best_time_q;
	logic [40:0] best_el_q, prod_q;

	// step results
	logic        r_ign_q, r_sv_q, r_sp_q, r_cv_q, r_idle_q;
	logic [3:0]  r_sz_q, r_cz_q;
	logic [23:0] r_ss_q;
	logic        o_valid_q;

	// divider
	logic        div_start, div_done;
	logic [31:0] div_dividend, div_quot;
	logic [15:0] div_divisor, div_rem;

	ipss_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	logic [IDX_W-1:0] ix;
	logic [3:0]  rd_zone;
	logic [15:0] rd_hyd, rd_pulse, rd_pause;
	logic [23:0] rd_rt;
	logic [31:0] rd_next;
	logic        rd_prog;

	assign ix       = idx_q[IDX_W-1:0];
	assign rd_zone  = e_zone_q[ix];
	assign rd_hyd   = e_hyd_q[ix];
	assign rd_rt    = e_rt_q[ix];
	assign rd_next  = e_next_q[ix];
	assign rd_prog  = e_prog_q[ix];
	assign rd_pulse = e_pulse_q[ix];
	assign rd_pause = e_pause_q[ix];

	assign div_start    = (op == OP_EL_DIV);
	assign div_dividend = {8'd0, rd_rt};
	assign div_divisor  = rd_pulse;

	// second of minute: now mod 60 = 4 * ((now >> 2) mod 15) + now[1:0]
	// nibbles of now >> 2 summed and folded give the mod-15 part
	logic [6:0] nib_sum;
	logic [4:0] nib_fold;
	logic [3:0] m15;
	always_comb begin
		nib_sum = 7'(now_q[31:30]);
		for (int k = 0; k < 7; k++) begin
			nib_sum = nib_sum + 7'(now_q[4*k+2 +: 4]);
		end
		nib_fold = 5'(nib_sum[3:0]) + 5'(nib_sum[6:4]);
		m15      = (nib_fold >= 5'd15) ? 4'(nib_fold - 5'd15) : nib_fold[3:0];
	end

	// soak count from the quotient, exact multiples drop the trailing soak
	logic [23:0] soaks;
	always_comb begin
		soaks = div_quot[23:0];
		if (rd_pulse == 16'd0) begin
			soaks = '0;
		end else if (div_rem == 16'd0 && soaks != 24'd0) begin
			soaks = soaks - 24'd1;
		end
	end

	logic [40:0] el;
	assign el = {17'd0, rd_rt} + prod_q;

	// pulse selection for a start
	logic [23:0] pr_pulse, sel_pulse, new_rt;
	always_comb begin
		pr_pulse = (rd_hyd != 16'd0) ? {8'd0, rd_hyd} : {8'd0, rd_pulse};
		if (!rd_prog) begin
			sel_pulse = rd_rt;
			new_rt    = '0;
		end else if (pr_pulse == 24'd0 || rd_rt <= pr_pulse) begin
			sel_pulse = rd_rt;
			new_rt    = '0;
		end else begin
			sel_pulse = pr_pulse;
			new_rt    = rd_rt - pr_pulse;
		end
	end

	function automatic logic [31:0] sat_time(input logic [33:0] t);
		sat_time = (t > {2'b00, TIME_MAX}) ? TIME_MAX : t[31:0];
	endfunction

	logic [33:0] t_end, t_next, t_busy;
	assign t_end  = {2'b00, now_q} + {10'd0, sel_pulse};
	assign t_next = t_end + (rd_prog ? {18'd0, rd_pause} : 34'd0);
	assign t_busy = t_end + {26'd0, vip_q};

	logic [24:0] add_rt;
	assign add_rt = {1'b0, rd_rt} + {9'd0, run_q};

	always_ff @(posedge clk) begin
		unique case (op)
			OP_CAPTURE: begin
				cmd_q    <= cmd_t'(cmd);
				zone_q   <= zone;
				run_q    <= run_seconds;
				sched_q  <= scheduled;
				hyd_q    <= hydrate_seconds;
				cpulse_q <= cycle_pulse;
				spause_q <= soak_pause;
				manual_q <= manual_only;
				now_q    <= now_seconds;
			end
			OP_ACT_UPDATE: begin
				e_rt_q[ix] <= add_rt[24] ? RUNTIME_MAX : add_rt[23:0];
				if (rd_next == 32'd0) e_next_q[ix] <= now_q;
			end
			OP_APPEND: begin
				e_zone_q[ix]  <= zone_q;
				e_hyd_q[ix]   <= hyd_q;
				e_rt_q[ix]    <= {8'd0, run_q};
				e_prog_q[ix]  <= sched_q;
				e_pulse_q[ix] <= cpulse_q;
				e_pause_q[ix] <= spause_q;
				e_next_q[ix]  <= now_q;
			end
			OP_PRUNE_POP: e_next_q[ix] <= '0;
			OP_TICK_BEGIN: begin
				best_time_q <= {1'b0, now_q} + 33'd1;
				best_el_q   <= '0;
			end
			OP_MOD_DONE: mod_ok_q <= (m15 == 4'd0) && !now_q[1];
			OP_EL_MUL:   prod_q <= 41'(rd_pause) * 41'(soaks);
			OP_EL_CMP: begin
				if ({1'b0, rd_next} < best_time_q) begin
					best_idx_q  <= ix;
					best_time_q <= {1'b0, rd_next};
					best_el_q   <= el;
				end else if (el > best_el_q) begin
					best_idx_q <= ix;
					best_el_q  <= el;
				end
			end
			OP_START: begin
				e_rt_q[ix]   <= new_rt;
				e_hyd_q[ix]  <= '0;
				e_next_q[ix] <= sat_time(t_next);
				r_sz_q       <= rd_zone;
				r_ss_q       <= sel_pulse;
				r_sp_q       <= rd_prog;
			end
			default: ;
		endcase
		if (op == OP_CAPTURE) begin
			r_sz_q <= '0;
			r_ss_q <= '0;
			r_sp_q <= 1'b0;
			r_cz_q <= '0;
		end
		if (op == OP_TICK_BEGIN && run_v_q && busy_q == 32'd0) r_cz_q <= run_z_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			idx_q     <= '0;
			busy_q    <= '0;
			pend_q    <= '0;
			run_v_q   <= 1'b0;
			run_z_q   <= '0;
			vip_q     <= VIP_RESET;
			pick_q    <= 1'b0;
			r_ign_q   <= 1'b0;
			r_sv_q    <= 1'b0;
			r_cv_q    <= 1'b0;
			r_idle_q  <= 1'b0;
			o_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) vip_q <= cfg_data;
			if (op == OP_OUT_LOAD) begin
				o_valid_q <= 1'b1;
			end else if (out_valid && out_ready) begin
				o_valid_q <= 1'b0;
			end
			unique case (op)
				OP_CAPTURE: begin
					idx_q   <= '0;
					r_ign_q <= 1'b0;
					r_sv_q  <= 1'b0;
					r_cv_q  <= 1'b0;
				end
				OP_IGNORE:   r_ign_q <= 1'b1;
				OP_APPEND:   count_q <= count_q + 1'b1;
				OP_STOP: begin
					count_q <= '0;
					busy_q  <= '0;
					pend_q  <= '0;
				end
				OP_IDX_INC:   idx_q <= idx_q + 1'b1;
				OP_PRUNE_IDX: idx_q <= count_q - 1'b1;
				OP_PRUNE_POP: count_q <= count_q - 1'b1;
				OP_TICK_BEGIN: begin
					idx_q  <= '0;
					pick_q <= 1'b0;
					if (run_v_q) begin
						r_cv_q  <= busy_q == 32'd0;
						run_v_q <= 1'b0;
						run_z_q <= '0;
						pend_q  <= '0;
					end
				end
				OP_EL_CMP: begin
					idx_q <= idx_q + 1'b1;
					if ({1'b0, rd_next} < best_time_q || el > best_el_q) pick_q <= 1'b1;
				end
				OP_SEL_BEST: idx_q <= {1'b0, best_idx_q};
				OP_START: begin
					busy_q  <= sat_time(t_busy);
					pend_q  <= sat_time(t_end);
					run_v_q <= 1'b1;
					run_z_q <= rd_zone;
					r_sv_q  <= 1'b1;
				end
				OP_IDLE_SET: r_idle_q <= 1'b1;
				OP_IDLE_CLR: r_idle_q <= 1'b0;
				OP_IDLE_BEGIN: begin
					idx_q    <= '0;
					r_idle_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// result register, loaded once per transaction
	logic        o_ign_q, o_sv_q, o_sp_q, o_cv_q, o_av_q, o_idle_q;
	logic [3:0]  o_sz_q, o_cz_q, o_az_q;
	logic [23:0] o_ss_q;

	always_ff @(posedge clk) begin
		if (op == OP_OUT_LOAD) begin
			o_ign_q  <= r_ign_q;
			o_sv_q   <= r_sv_q;
			o_sz_q   <= r_sz_q;
			o_ss_q   <= r_ss_q;
			o_sp_q   <= r_sp_q;
			o_cv_q   <= r_cv_q;
			o_cz_q   <= r_cz_q;
			o_av_q   <= run_v_q;
			o_az_q   <= run_z_q;
			o_idle_q <= r_idle_q;
		end
	end

	assign out_valid       = o_valid_q;
	assign ignored         = o_ign_q;
	assign start_valid     = o_sv_q;
	assign start_zone      = o_sz_q;
	assign start_seconds   = o_ss_q;
	assign start_scheduled = o_sp_q;
	assign cancel_valid    = o_cv_q;
	assign cancel_zone     = o_cz_q;
	assign active_valid    = o_av_q;
	assign active_zone     = o_az_q;
	assign idle            = o_idle_q;

	always_comb begin
		st.cmd          = cmd_q;
		st.rej          = manual_q & sched_q;
		st.at_end       = idx_q == count_q;
		st.zone_match   = rd_zone == zone_q;
		st.full         = count_q == CNT_W'(MAX_ZONES);
		st.cnt_zero     = count_q == '0;
		st.prune_ok     = (rd_rt == 24'd0) && (rd_next < now_q);
		st.now_zero     = now_q == 32'd0;
		st.now_gt_busy  = now_q > busy_q;
		st.div_done     = div_done;
		st.cand         = (rd_rt != 24'd0) && !(rd_prog && !mod_ok_q) &&
		                  (rd_next != 32'd0) && ({1'b0, rd_next} <= best_time_q);
		st.p_zero       = rd_pulse == 16'd0;
		st.pick_valid   = pick_q;
		st.pulse_end_ge = pend_q >= now_q;
		st.rt_nz        = rd_rt != 24'd0;
		st.out_free     = !o_valid_q || out_ready;
	end

	`IPSS_ASSERT_ALWAYS(a_count_range, count_q <= CNT_W'(MAX_ZONES), "queue count overflow")
	`IPSS_ASSERT_IMPL(a_start_active, out_valid && start_valid, active_valid, "start without active")
	`IPSS_ASSERT_IMPL(a_start_not_ign, out_valid && start_valid, !ignored, "start and ignored")

endmodule

// ===== rtl/irrigation_pulse_soak_scheduler.sv =====
// an activate walks the queue before the idle check; a rejected activate or a stop goes to it directly
// a nonzero tick prunes finished tail entries and, once past the busy time, walks the queue, running
//   the divider for each candidate with a nonzero cycle pulse; every command ends with the idle check
// throughput: one transaction in flight, the next is taken once the result is loaded
// reset: arst_n clears queue count, timers and running zone; pause register returns to 1
// entry store has no reset, entries are read only below the queue count
// ----------------------------------------------------------------------------
// irrigation_pulse_soak_scheduler
// valve activation queue with pulse/soak cycling, one zone running at a time
// ----------------------------------------------------------------------------
module irrigation_pulse_soak_scheduler import ipss_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// pause register write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data,
	// command channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [3:0]  zone,
	input  logic [15:0] run_seconds,
	input  logic        scheduled,
	input  logic [15:0] hydrate_seconds,
	input  logic [15:0] cycle_pulse,
	input  logic [15:0] soak_pause,
	input  logic        manual_only,
	input  logic [31:0] now_seconds,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic        ignored,
	output logic        start_valid,
	output logic [3:0]  start_zone,
	output logic [23:0] start_seconds,
	output logic        start_scheduled,
	output logic        cancel_valid,
	output logic [3:0]  cancel_zone,
	output logic        active_valid,
	output logic [3:0]  active_zone,
	output logic        idle
);

	op_t          op;
	ipss_status_t st;
	logic         cfg_we;

	// register writes land only while no transaction is open
	assign cfg_ready = in_ready;
	assign cfg_we    = cfg_valid & cfg_ready;

	// sequencer: decodes the command and walks the queue
	ipss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.op       (op)
	);

	// datapath: entry store, divider, selection and result register
	ipss_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.op              (op),
		.st              (st),
		.cfg_valid       (cfg_we),
		.cfg_data        (cfg_data),
		.cmd             (cmd),
		.zone            (zone),
		.run_seconds     (run_seconds),
		.scheduled       (scheduled),
		.hydrate_seconds (hydrate_seconds),
		.cycle_pulse     (cycle_pulse),
		.soak_pause      (soak_pause),
		.manual_only     (manual_only),
		.now_seconds     (now_seconds),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.ignored         (ignored),
		.start_valid     (start_valid),
		.start_zone      (start_zone),
		.start_seconds   (start_seconds),
		.start_scheduled (start_scheduled),
		.cancel_valid    (cancel_valid),
		.cancel_zone     (cancel_zone),
		.active_valid    (active_valid),
		.active_zone     (active_zone),
		.idle            (idle)
	);

endmodule

// ===== verif/tb_irrigation_pulse_soak_scheduler.sv =====
// ----------------------------------------------------------------------------
// tb_irrigation_pulse_soak_scheduler
// self-checking bench for the pulse/soak valve scheduler: every command
// transaction goes through a cycle-free model of the queue, and each result
// transaction is checked field by field against the oldest prediction
// ----------------------------------------------------------------------------
module tb_irrigation_pulse_soak_scheduler;
	import ipss_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_CYCLES = 20000;
	localparam int SETTLE_CYCLES   = 100;

	typedef struct packed {
		cmd_t        c;
		logic [3:0]  zone;
		logic [15:0] run;
		logic        sched;
		logic [15:0] hyd;
		logic [15:0] pulse;
		logic [15:0] soak;
		logic        manual;
		logic [31:0] now;
	} valve_cmd_t;

	typedef struct packed {
		logic        ignored;
		logic        start_valid;
		logic [3:0]  start_zone;
		logic [23:0] start_seconds;
		logic        start_scheduled;
		logic        cancel_valid;
		logic [3:0]  cancel_zone;
		logic        active_valid;
		logic [3:0]  active_zone;
		logic        idle;
	} valve_status_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  cmd;
	logic [3:0]  zone;
	logic [15:0] run_seconds;
	logic        scheduled;
	logic [15:0] hydrate_seconds;
	logic [15:0] cycle_pulse;
	logic [15:0] soak_pause;
	logic        manual_only;
	logic [31:0] now_seconds;
	logic        out_valid;
	logic        out_ready;
	valve_status_t got;

	irrigation_pulse_soak_scheduler i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.cmd             (cmd),
		.zone            (zone),
		.run_seconds     (run_seconds),
		.scheduled       (scheduled),
		.hydrate_seconds (hydrate_seconds),
		.cycle_pulse     (cycle_pulse),
		.soak_pause      (soak_pause),
		.manual_only     (manual_only),
		.now_seconds     (now_seconds),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.ignored         (got.ignored),
		.start_valid     (got.start_valid),
		.start_zone      (got.start_zone),
		.start_seconds   (got.start_seconds),
		.start_scheduled (got.start_scheduled),
		.cancel_valid    (got.cancel_valid),
		.cancel_zone     (got.cancel_zone),
		.active_valid    (got.active_valid),
		.active_zone     (got.active_zone),
		.idle            (got.idle)
	);

	// clock, 20 ns period
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// ---------------------------------------------------------------- model state
	logic [3:0]  q_zone  [MAX_ZONES];
	logic [15:0] q_hyd   [MAX_ZONES];
	logic [23:0] q_run   [MAX_ZONES];
	logic [31:0] q_next  [MAX_ZONES];
	logic        q_prog  [MAX_ZONES];
	logic [15:0] q_pulse [MAX_ZONES];
	logic [15:0] q_soak  [MAX_ZONES];
	int          q_count;
	logic [31:0] busy_until;
	logic [31:0] pulse_end;
	logic        running_valid;
	logic [3:0]  running_zone;
	logic [7:0]  index_pause;

	valve_status_t pending_status[$];
	int            mismatch_count;
	int            send_idle_pct;
	int            recv_idle_pct;
	int            quiet_cycles;
	logic [31:0]   wall_clock;

	// clamp a time sum to 32 bits
	function automatic logic [31:0] clamp_time(longint unsigned t);
		return (t > longint'(TIME_MAX)) ? TIME_MAX : t[31:0];
	endfunction

	// total wall time an entry still needs: runtime plus the soaks in between
	function automatic longint unsigned soak_span(int k);
		longint unsigned rt;
		longint unsigned p;
		longint unsigned soaks;
		rt = q_run[k];
		p = q_pulse[k];
		soaks = 0;
		if (p != 0) begin
			soaks = rt / p;
			// exact multiple: no soak after the last pulse
			if (rt % p == 0 && soaks > 0)
				soaks = soaks - 1;
		end
		return rt + longint'(q_soak[k]) * soaks;
	endfunction

	// advance the queue model by one command and build its status
	task automatic schedule_step(input valve_cmd_t it, output valve_status_t r);
		logic found;
		logic [24:0] sum;
		int pick;
		longint unsigned best_time;
		longint unsigned best_el;
		longint unsigned nx;
		longint unsigned el;
		logic [31:0] pulse;
		logic busy_flag;
		r = '0;
		case (it.c)
			CMD_ACTIVATE: begin
				if (it.manual && it.sched) begin
					// manual-only zone refuses a program request
					r.ignored = 1'b1;
				end else begin
					found = 1'b0;
					for (int i = 0; i < q_count; i++) begin
						if (!found && q_zone[i] == it.zone) begin
							// top up an existing entry, saturating
							sum = q_run[i] + it.run;
							q_run[i] = (sum > RUNTIME_MAX) ? RUNTIME_MAX : sum[23:0];
							if (q_next[i] == 0)
								q_next[i] = it.now;
							found = 1'b1;
						end
					end
					if (!found) begin
						if (q_count < MAX_ZONES) begin
							q_zone[q_count]  = it.zone;
							q_hyd[q_count]   = it.hyd;
							q_run[q_count]   = {8'd0, it.run};
							q_prog[q_count]  = it.sched;
							q_pulse[q_count] = it.pulse;
							q_soak[q_count]  = it.soak;
							q_next[q_count]  = it.now;
							q_count++;
						end else begin
							r.ignored = 1'b1;
						end
					end
				end
			end
			CMD_STOP: begin
				for (int i = 0; i < q_count; i++) begin
					q_hyd[i]  = '0;
					q_run[i]  = '0;
					q_next[i] = '0;
				end
				q_count = 0;
				busy_until = '0;
				pulse_end = '0;
			end
			CMD_TICK: begin
				if (it.now != 0) begin
					// drop finished entries at the tail
					while (q_count > 0 && q_run[q_count-1] == 0 &&
						q_next[q_count-1] < it.now) begin
						q_next[q_count-1] = '0;
						q_count--;
					end
					if (it.now > busy_until) begin
						pick = -1;
						best_time = longint'(it.now) + 1;
						best_el = 0;
						if (running_valid) begin
							// stop came before the pulse ended
							if (busy_until == 0) begin
								r.cancel_valid = 1'b1;
								r.cancel_zone = running_zone;
							end
							running_valid = 1'b0;
							running_zone = '0;
							pulse_end = '0;
						end
						for (int i = 0; i < q_count; i++) begin
							if (q_run[i] == 0)
								continue;
							// program entries only at second 0 or 1
							if (q_prog[i] && (it.now % 60) > 1)
								continue;
							nx = q_next[i];
							if (nx == 0 || nx > best_time)
								continue;
							el = soak_span(i);
							if (nx < best_time) begin
								pick = i;
								best_time = nx;
								best_el = el;
							end else if (el > best_el) begin
								pick = i;
								best_el = el;
							end
						end
						if (pick >= 0) begin
							if (!q_prog[pick]) begin
								// manual entry runs in one go
								pulse = {8'd0, q_run[pick]};
								q_run[pick] = '0;
								q_hyd[pick] = '0;
								q_next[pick] = clamp_time(longint'(it.now) + pulse);
							end else begin
								pulse = {16'd0, q_pulse[pick]};
								if (q_hyd[pick] > 0) begin
									pulse = {16'd0, q_hyd[pick]};
									q_hyd[pick] = '0;
								end
								if (pulse == 0 || q_run[pick] <= pulse) begin
									pulse = {8'd0, q_run[pick]};
									q_run[pick] = '0;
								end else begin
									q_run[pick] = q_run[pick] - pulse[23:0];
								end
								q_next[pick] = clamp_time(longint'(it.now) + pulse +
									q_soak[pick]);
							end
							busy_until = clamp_time(longint'(it.now) + pulse + index_pause);
							pulse_end = clamp_time(longint'(it.now) + pulse);
							running_valid = 1'b1;
							running_zone = q_zone[pick];
							r.start_valid = 1'b1;
							r.start_zone = q_zone[pick];
							r.start_seconds = pulse[23:0];
							r.start_scheduled = q_prog[pick];
						end
					end
				end
			end
			default: ;
		endcase
		r.active_valid = running_valid;
		r.active_zone = running_zone;
		// idle: nothing running now and no runtime left
		busy_flag = 1'b0;
		if (q_count != 0) begin
			if (pulse_end >= it.now) begin
				busy_flag = 1'b1;
			end else begin
				for (int i = 0; i < q_count; i++)
					if (q_run[i] > 0)
						busy_flag = 1'b1;
			end
		end
		r.idle = !busy_flag;
	endtask

	// ------------------------------------------------- prediction and checking
	always @(posedge clk) begin
		valve_status_t want;
		valve_cmd_t    seen;
		if (out_valid && out_ready) begin
			if (pending_status.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: unexpected result transaction %p", $realtime, got);
			end else begin
				want = pending_status.pop_front();
				if (want !== got) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: mismatch\n  expected %p\n  actual   %p",
							$realtime, want, got);
				end
			end
		end
		if (in_valid && in_ready) begin
			seen.c      = cmd_t'(cmd);
			seen.zone   = zone;
			seen.run    = run_seconds;
			seen.sched  = scheduled;
			seen.hyd    = hydrate_seconds;
			seen.pulse  = cycle_pulse;
			seen.soak   = soak_pause;
			seen.manual = manual_only;
			seen.now    = now_seconds;
			schedule_step(seen, want);
			pending_status.push_back(want);
		end
		if (cfg_valid && cfg_ready)
			index_pause <= cfg_data;
	end

	// receiver stalls
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// watchdog on cycles with no transaction anywhere
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
			|| !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_CYCLES) begin
			$display("%0t: watchdog expired", $realtime);
			$display("tb_irrigation_pulse_soak_scheduler: done, errors");
			$finish;
		end
	end

	// ------------------------------------------------------------ drive helpers
	function automatic valve_cmd_t mk_cmd(cmd_t c, logic [3:0] z, logic [15:0] run,
		logic sched, logic [15:0] hyd, logic [15:0] pulse, logic [15:0] soak,
		logic manual, logic [31:0] now);
		valve_cmd_t it;
		it.c = c;
		it.zone = z;
		it.run = run;
		it.sched = sched;
		it.hyd = hyd;
		it.pulse = pulse;
		it.soak = soak;
		it.manual = manual;
		it.now = now;
		return it;
	endfunction

	// one command transaction, with a random gap in front
	task automatic send_cmd(input valve_cmd_t it);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd             <= it.c;
		zone            <= it.zone;
		run_seconds     <= it.run;
		scheduled       <= it.sched;
		hydrate_seconds <= it.hyd;
		cycle_pulse     <= it.pulse;
		soak_pause      <= it.soak;
		manual_only     <= it.manual;
		now_seconds     <= it.now;
		in_valid        <= 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	// hold off the sender until every prediction has been matched
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_status.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_pause(input logic [7:0] value);
		drain_results();
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// ------------------------------------------------------------------- tests
	// extremes and each special case, in one walk through a few minutes
	task automatic test_special_cases();
		send_cmd(mk_cmd(CMD_ACTIVATE, 4'd0, 16'd10, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			1'b0, 32'd100));
		send_cmd(mk_cmd(CMD_ACTIVATE, 4'd1, 16'd20, 1'b1, 16'd3, 16'd4, 16'd5, 1'b0,
			32'd100));
		// manual-only zone refuses a program request
		send_cmd(mk_cmd(CMD_ACTIVATE, 4'd2, 16'd9, 1'b1, 16'd0, 16'd0, 16'd0, 1'b1,
			32'd100));
		// top up an existing entry
		send_cmd(mk_cmd(CMD_ACTIVATE, 4'd1, 16'hFFFF, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0,
			32'd100));
		// program entry with no cycling
		send_cmd(mk_cmd(CMD_ACTIVATE, 4'd3, 16'd7, 1'b1, 16'd0, 16'd0, 16'd2, 1'b0,
			32'd100));
		// next-on of zero: never becomes ready
		send_cmd(mk_cmd(CMD_ACTIVATE, 4'd4, 16'd5, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0,
			32'd0));
		// tick at time zero does nothing
		send_cmd(mk_cmd(CMD_TICK, 4'd0, 16'd0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 32'd0));
		send_cmd(mk_cmd(CMD_TICK, 4'd0, 16'd0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 32'd101));
		send_cmd(mk_cmd(CMD_TICK, 4'd0, 16'd0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 32'd105));
		send_cmd(mk_cmd(CMD_TICK, 4'd0, 16'd0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 32'd120));
		send_cmd(mk_cmd(CMD_TICK, 4'd0, 16'd0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 32'd181));
		send_cmd(mk_cmd(CMD_NOP, 4'hF, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			1'b1, 32'hFFFFFFFF));
		// stop with a pulse running, cancel shows on the next tick
		send_cmd(mk_cmd(CMD_STOP, 4'd0, 16'd0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 32'd182));
		send_cmd(mk_cmd(CMD_TICK, 4'd0, 16'd0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 32'd183));
		// empty entry at the tail gets pruned
		send_cmd(mk_cmd(CMD_ACTIVATE, 4'd15, 16'd0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0,
			32'd300));
		send_cmd(mk_cmd(CMD_TICK, 4'd0, 16'd0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 32'd301));
		// time sums saturate near the top of the clock
		send_cmd(mk_cmd(CMD_ACTIVATE, 4'd9, 16'hFFFF, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0,
			32'hFFFFFFF0));
		send_cmd(mk_cmd(CMD_TICK, 4'd0, 16'd0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0,
			32'hFFFFFFFF));
		send_cmd(mk_cmd(CMD_STOP, 4'd0, 16'd0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 32'd400));
	endtask

	// runtime top-up saturates at the 24-bit maximum
	task automatic test_runtime_saturation();
		for (int i = 0; i < 258; i++)
			send_cmd(mk_cmd(CMD_ACTIVATE, 4'd5, 16'hFFFF, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0,
				32'd500));
		send_cmd(mk_cmd(CMD_TICK, 4'd0, 16'd0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 32'd501));
		send_cmd(mk_cmd(CMD_STOP, 4'd0, 16'd0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 32'd502));
		send_cmd(mk_cmd(CMD_TICK, 4'd0, 16'd0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 32'd503));
	endtask

	// mostly activates and advancing ticks, with stops, no-ops and time jumps
	task automatic test_random_traffic(input int count);
		valve_cmd_t it;
		int r;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(99);
			it = mk_cmd(CMD_NOP, 4'($urandom), 16'($urandom), 1'($urandom), 16'($urandom),
				16'($urandom), 16'($urandom), 1'($urandom), wall_clock);
			if (r < 40) begin
				it.c = CMD_ACTIVATE;
				it.zone = ($urandom_range(3) == 0) ? 4'($urandom) : 4'($urandom_range(5));
				it.run = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(40));
				it.hyd = ($urandom_range(2) == 0) ? 16'd0 : 16'($urandom_range(8));
				it.pulse = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(12));
				it.soak = 16'($urandom_range(10));
				it.manual = ($urandom_range(4) == 0);
				if ($urandom_range(19) == 0) begin
					it.hyd = 16'($urandom);
					it.pulse = 16'($urandom);
					it.soak = 16'($urandom);
				end
			end else if (r < 90) begin
				it.c = CMD_TICK;
				if ($urandom_range(6) == 0)
					wall_clock = wall_clock - (wall_clock % 60) + 60 + $urandom_range(1);
				else
					wall_clock = wall_clock + $urandom_range(1, 6);
				it.now = ($urandom_range(49) == 0) ? 32'd0 : wall_clock;
			end else if (r < 95) begin
				it.c = CMD_STOP;
				// occasionally jump the clock anywhere, the stop clears busy time
				if ($urandom_range(4) == 0)
					wall_clock = ($urandom_range(1) == 0) ? $urandom :
						32'hFFFFFF00 + $urandom_range(200);
				if (wall_clock > 32'hFFFF0000 && $urandom_range(1) == 0)
					wall_clock = $urandom_range(1000, 100000);
			end
			send_cmd(it);
		end
	endtask

	// --------------------------------------------------------------------- main
	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		cmd = CMD_NOP;
		zone = '0;
		run_seconds = '0;
		scheduled = 1'b0;
		hydrate_seconds = '0;
		cycle_pulse = '0;
		soak_pause = '0;
		manual_only = 1'b0;
		now_seconds = '0;
		out_ready = 1'b0;
		mismatch_count = 0;
		quiet_cycles = 0;
		q_count = 0;
		busy_until = '0;
		pulse_end = '0;
		running_valid = 1'b0;
		running_zone = '0;
		index_pause = VIP_RESET;
		wall_clock = 32'd600;
		send_idle_pct = 38;
		recv_idle_pct = 64;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default pause register value first
		test_special_cases();
		test_runtime_saturation();
		write_pause(8'd0);
		test_random_traffic(120);
		drain_results();
		test_random_traffic(60);

		send_idle_pct = 64;
		recv_idle_pct = 38;
		write_pause(8'd255);
		test_random_traffic(120);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_pause(8'($urandom_range(2, 20)));
		test_random_traffic(120);
		drain_results();

		if (mismatch_count == 0 && pending_status.size() == 0) begin
			$display("tb_irrigation_pulse_soak_scheduler: done, clean");
		end else begin
			$display("tb_irrigation_pulse_soak_scheduler: done, errors");
		end
		$finish;
	end

endmodule
